FILE: rtl/core/rlf_pkg.sv
`default_nettype none
// Package for the RGB LED fade controller: widths, command and mode codes,
// beat payload types and the control and status groups between the FSM and datapath.
// No dependencies.
package rlf_pkg;

    localparam int COLOUR_BITS    = 8;
    localparam int INTERVAL_BITS  = 16;
    localparam int CMD_BITS       = 3;
    localparam int MODE_BITS      = 3;
    localparam int ZONE_BITS      = 3;
    localparam int NUM_LEVELS     = 6;
    localparam int LEVEL_BITS     = 3 * COLOUR_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int LEVEL_IDX_BITS = 3;

    localparam logic [INTERVAL_BITS-1:0] LONG_WAIT  = INTERVAL_BITS'(20);
    localparam logic [INTERVAL_BITS-1:0] SHORT_WAIT = INTERVAL_BITS'(10);

    localparam logic [CMD_BITS-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_MODE   = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_SENSOR = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_ALARM  = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_FADE   = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_SET    = 3'd5;

    localparam logic [MODE_BITS-1:0] MODE_OFF     = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_DAY     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_EVENING = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_NIGHT   = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_HIGH    = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_DIM     = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_MANUAL  = 3'd6;
    localparam logic [MODE_BITS-1:0] MODE_ALL_OFF = 3'd7;

    localparam logic [LEVEL_IDX_BITS-1:0] LVL_BRIGHT = 3'd0;
    localparam logic [LEVEL_IDX_BITS-1:0] LVL_DIM    = 3'd1;
    localparam logic [LEVEL_IDX_BITS-1:0] LVL_NIGHT  = 3'd4;
    localparam logic [LEVEL_IDX_BITS-1:0] LVL_OFF    = 3'd5;

    localparam logic [ZONE_BITS-1:0] ZONE_MAX = 3'd5;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_FADE,
        OP_ALL_OFF,
        OP_SET
    } op_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]      command;
        logic [MODE_BITS-1:0]     mode_value;
        logic [ZONE_BITS-1:0]     zone;
        logic                     alarm;
        logic [COLOUR_BITS-1:0]   red_in;
        logic [COLOUR_BITS-1:0]   green_in;
        logic [COLOUR_BITS-1:0]   blue_in;
        logic [INTERVAL_BITS-1:0] step_interval;
    } item_t;

    typedef struct packed {
        logic [COLOUR_BITS-1:0] red_out;
        logic [COLOUR_BITS-1:0] green_out;
        logic [COLOUR_BITS-1:0] blue_out;
        logic                   fading;
        logic [MODE_BITS-1:0]   mode_out;
    } result_t;

    typedef struct packed {
        logic                      accept;
        logic                      tgt_load;
        logic                      tgt_from_level;
        logic [LEVEL_IDX_BITS-1:0] tgt_level;
        logic                      tgt_short;
        logic                      apply;
        op_t                       op;
        logic                      store_mode;
        logic                      store_zone;
        logic                      store_alarm;
        logic                      emit;
    } ctl_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]  command;
        logic [MODE_BITS-1:0] mode_value;
        logic [ZONE_BITS-1:0] zone_sat;
        logic                 alarm;
        logic [MODE_BITS-1:0] mode_now;
        logic [ZONE_BITS-1:0] zone_now;
        logic                 alarm_now;
        logic                 out_free;
    } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/rlf_ctrl.sv
`default_nettype none
// Controller FSM of the RGB LED fade controller: decodes each event into
// target selection and a datapath operation. Depends on rlf_pkg.
module rlf_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_valid,
    output logic              item_stall,
    input  rlf_pkg::sts_t     sts,
    output rlf_pkg::ctl_t     ctl
);
    import rlf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_APPLY  = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg;
    logic   store_mode_reg, store_zone_reg, store_alarm_reg;

    op_t                       dec_op;
    logic                      dec_store_mode, dec_store_zone, dec_store_alarm;
    logic                      dec_from_level, dec_short;
    logic [LEVEL_IDX_BITS-1:0] dec_level;

    always_comb
    begin
        dec_op          = OP_NONE;
        dec_store_mode  = 1'b0;
        dec_store_zone  = 1'b0;
        dec_store_alarm = 1'b0;
        dec_from_level  = 1'b1;
        dec_short       = 1'b0;
        dec_level       = LVL_OFF;
        case (sts.command)
            CMD_TICK:
            begin
                dec_op = OP_TICK;
            end
            CMD_MODE:
            begin
                if (sts.mode_value != sts.mode_now)
                begin
                    dec_store_mode = 1'b1;
                    case (sts.mode_value)
                        MODE_OFF:
                        begin
                            dec_op    = OP_FADE;
                            dec_level = LVL_OFF;
                            dec_short = 1'b1;
                        end
                        MODE_DAY:
                        begin
                            dec_op    = OP_FADE;
                            dec_level = LVL_BRIGHT;
                        end
                        MODE_EVENING:
                        begin
                            dec_op    = OP_FADE;
                            dec_level = sts.zone_now;
                        end
                        MODE_NIGHT:
                        begin
                            dec_op    = OP_FADE;
                            dec_level = LVL_NIGHT;
                        end
                        MODE_HIGH:
                        begin
                            dec_op    = OP_FADE;
                            dec_level = LVL_BRIGHT;
                            dec_short = 1'b1;
                        end
                        MODE_DIM:
                        begin
                            dec_op    = OP_FADE;
                            dec_level = LVL_DIM;
                            dec_short = 1'b1;
                        end
                        MODE_ALL_OFF:
                        begin
                            dec_op = OP_ALL_OFF;
                        end
                        default:
                        begin
                            dec_op = OP_NONE;
                        end
                    endcase
                end
            end
            CMD_SENSOR:
            begin
                dec_store_zone = 1'b1;
                case (sts.mode_now)
                    MODE_OFF, MODE_DAY:
                    begin
                        dec_op    = OP_FADE;
                        dec_level = LVL_BRIGHT;
                    end
                    MODE_EVENING:
                    begin
                        dec_op    = OP_FADE;
                        dec_level = sts.zone_sat;
                    end
                    MODE_NIGHT:
                    begin
                        dec_op    = OP_FADE;
                        dec_level = sts.alarm_now ? LVL_DIM : LVL_NIGHT;
                        dec_short = sts.alarm_now;
                    end
                    default:
                    begin
                        dec_op = OP_NONE;
                    end
                endcase
            end
            CMD_ALARM:
            begin
                dec_store_alarm = 1'b1;
                if (sts.mode_now == MODE_NIGHT)
                begin
                    dec_op    = OP_FADE;
                    dec_level = sts.alarm ? LVL_DIM : LVL_NIGHT;
                    dec_short = sts.alarm;
                end
            end
            CMD_FADE:
            begin
                dec_op         = OP_FADE;
                dec_from_level = 1'b0;
            end
            CMD_SET:
            begin
                dec_op = OP_SET;
            end
            default:
            begin
                dec_op = OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_NONE;
            store_mode_reg  <= 1'b0;
            store_zone_reg  <= 1'b0;
            store_alarm_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DECODE)
            begin
                op_reg          <= dec_op;
                store_mode_reg  <= dec_store_mode;
                store_zone_reg  <= dec_store_zone;
                store_alarm_reg <= dec_store_alarm;
            end
        end
    end

    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        ctl.accept         = (state_reg == ST_IDLE) && item_valid;
        ctl.tgt_load       = (state_reg == ST_DECODE);
        ctl.tgt_from_level = dec_from_level;
        ctl.tgt_level      = dec_level;
        ctl.tgt_short      = dec_short;
        ctl.apply          = (state_reg == ST_APPLY);
        ctl.op             = op_reg;
        ctl.store_mode     = store_mode_reg;
        ctl.store_zone     = store_zone_reg;
        ctl.store_alarm    = store_alarm_reg;
        ctl.emit           = (state_reg == ST_EMIT) && sts.out_free;
    end

endmodule
`default_nettype wire

FILE: rtl/core/rlf_datapath.sv
`default_nettype none
// Datapath of the RGB LED fade controller: level registers, color and fade
// state, incremental per-channel step arithmetic and the result register. Depends on rlf_pkg.
module rlf_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  rlf_pkg::item_t                       item,
    input  rlf_pkg::ctl_t                        ctl,
    output rlf_pkg::sts_t                        sts,
    input  wire logic                            cfg_we,
    input  wire logic [rlf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [rlf_pkg::LEVEL_BITS-1:0]  cfg_data,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output rlf_pkg::result_t                     result
);
    import rlf_pkg::*;

    localparam int CB = COLOUR_BITS;

    logic [LEVEL_BITS-1:0]    level_reg [NUM_LEVELS];
    item_t                    item_reg;
    logic [CB-1:0]            colour_reg [3];
    logic [CB-1:0]            target_reg [3];
    logic [CB-1:0]            pos_reg [3];
    logic [CB-1:0]            rem_reg [3];
    logic signed [CB:0]       delta_reg [3];
    logic [CB-1:0]            steps_total_reg;
    logic [CB-1:0]            steps_done_reg;
    logic [INTERVAL_BITS-1:0] ticks_reg;
    logic [INTERVAL_BITS-1:0] interval_reg;
    logic [INTERVAL_BITS-1:0] interval_tgt_reg;
    logic                     fade_active_reg;
    logic [MODE_BITS-1:0]     mode_reg;
    logic [ZONE_BITS-1:0]     zone_reg;
    logic                     alarm_reg;
    logic                     result_valid_reg;
    result_t                  result_reg;

    logic [LEVEL_BITS-1:0]    level_sel;
    logic [ZONE_BITS-1:0]     zone_sat;
    logic signed [CB:0]       diff [3];
    logic [CB-1:0]            absd [3];
    logic [CB-1:0]            max01;
    logic [CB-1:0]            most;
    logic signed [CB+1:0]     acc [3];
    logic signed [CB+1:0]     acc_up [3];
    logic signed [CB+1:0]     acc_dn [3];
    logic signed [CB+1:0]     m_ext;
    logic [CB-1:0]            pos_next [3];
    logic [CB-1:0]            rem_next [3];
    logic [CB-1:0]            steps_done_next;

    always_comb
    begin
        case (ctl.tgt_level)
            3'd0:    level_sel = level_reg[0];
            3'd1:    level_sel = level_reg[1];
            3'd2:    level_sel = level_reg[2];
            3'd3:    level_sel = level_reg[3];
            3'd4:    level_sel = level_reg[4];
            default: level_sel = level_reg[5];
        endcase
    end

    assign zone_sat = (item_reg.zone > ZONE_MAX) ? ZONE_MAX : item_reg.zone;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            diff[c] = $signed({1'b0, target_reg[c]}) - $signed({1'b0, colour_reg[c]});
            if (diff[c][CB])
            begin
                absd[c] = CB'(-diff[c]);
            end
            else
            begin
                absd[c] = diff[c][CB-1:0];
            end
        end
        max01 = (absd[0] > absd[1]) ? absd[0] : absd[1];
        most  = (absd[2] > max01) ? absd[2] : max01;
    end

    assign m_ext           = $signed({2'b00, steps_total_reg});
    assign steps_done_next = steps_done_reg + 1'b1;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc[c]    = $signed({2'b00, rem_reg[c]}) + $signed({delta_reg[c][CB], delta_reg[c]});
            acc_up[c] = acc[c] + m_ext;
            acc_dn[c] = acc[c] - m_ext;
            if (acc[c] < 0)
            begin
                pos_next[c] = pos_reg[c] - 1'b1;
                rem_next[c] = acc_up[c][CB-1:0];
            end
            else if (acc[c] >= m_ext)
            begin
                pos_next[c] = pos_reg[c] + 1'b1;
                rem_next[c] = acc_dn[c][CB-1:0];
            end
            else
            begin
                pos_next[c] = pos_reg[c];
                rem_next[c] = acc[c][CB-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            item_reg <= item;
        end
        if (ctl.tgt_load)
        begin
            if (ctl.tgt_from_level)
            begin
                target_reg[0]    <= level_sel[3*CB-1:2*CB];
                target_reg[1]    <= level_sel[2*CB-1:CB];
                target_reg[2]    <= level_sel[CB-1:0];
                interval_tgt_reg <= ctl.tgt_short ? SHORT_WAIT : LONG_WAIT;
            end
            else
            begin
                target_reg[0]    <= item_reg.red_in;
                target_reg[1]    <= item_reg.green_in;
                target_reg[2]    <= item_reg.blue_in;
                interval_tgt_reg <= item_reg.step_interval;
            end
        end
        if (ctl.apply)
        begin
            if ((ctl.op == OP_FADE) && (most != '0))
            begin
                for (int c = 0; c < 3; c++)
                begin
                    pos_reg[c]   <= colour_reg[c];
                    rem_reg[c]   <= '0;
                    delta_reg[c] <= diff[c];
                end
            end
            else if ((ctl.op == OP_TICK) && fade_active_reg && (ticks_reg >= interval_reg))
            begin
                for (int c = 0; c < 3; c++)
                begin
                    pos_reg[c] <= pos_next[c];
                    rem_reg[c] <= rem_next[c];
                end
            end
        end
        if (ctl.emit)
        begin
            result_reg.red_out   <= colour_reg[0];
            result_reg.green_out <= colour_reg[1];
            result_reg.blue_out  <= colour_reg[2];
            result_reg.fading    <= fade_active_reg;
            result_reg.mode_out  <= mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                level_reg[i] <= '0;
            end
            for (int c = 0; c < 3; c++)
            begin
                colour_reg[c] <= '1;
            end
            steps_total_reg  <= '0;
            steps_done_reg   <= '0;
            ticks_reg        <= '0;
            interval_reg     <= '0;
            fade_active_reg  <= 1'b0;
            mode_reg         <= MODE_OFF;
            zone_reg         <= '0;
            alarm_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index < CFG_INDEX_BITS'(NUM_LEVELS)))
            begin
                level_reg[cfg_index] <= cfg_data;
            end

            if (ctl.apply)
            begin
                if (ctl.store_mode)
                begin
                    mode_reg <= item_reg.mode_value;
                end
                if (ctl.store_zone)
                begin
                    zone_reg <= zone_sat;
                end
                if (ctl.store_alarm)
                begin
                    alarm_reg <= item_reg.alarm;
                end
                case (ctl.op)
                    OP_TICK:
                    begin
                        if (fade_active_reg)
                        begin
                            if (ticks_reg < interval_reg)
                            begin
                                ticks_reg <= ticks_reg + 1'b1;
                            end
                            else
                            begin
                                ticks_reg      <= '0;
                                steps_done_reg <= steps_done_next;
                                for (int c = 0; c < 3; c++)
                                begin
                                    colour_reg[c] <= pos_next[c];
                                end
                                if (steps_done_next >= steps_total_reg)
                                begin
                                    fade_active_reg <= 1'b0;
                                end
                            end
                        end
                    end
                    OP_FADE:
                    begin
                        if (most == '0)
                        begin
                            fade_active_reg <= 1'b0;
                        end
                        else
                        begin
                            steps_total_reg <= most;
                            steps_done_reg  <= '0;
                            ticks_reg       <= '0;
                            interval_reg    <= interval_tgt_reg;
                            fade_active_reg <= 1'b1;
                        end
                    end
                    OP_ALL_OFF:
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            colour_reg[c] <= '1;
                        end
                        fade_active_reg <= 1'b0;
                    end
                    OP_SET:
                    begin
                        colour_reg[0] <= item_reg.red_in;
                        colour_reg[1] <= item_reg.green_in;
                        colour_reg[2] <= item_reg.blue_in;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (ctl.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.command    = item_reg.command;
        sts.mode_value = item_reg.mode_value;
        sts.zone_sat   = zone_sat;
        sts.alarm      = item_reg.alarm;
        sts.mode_now   = mode_reg;
        sts.zone_now   = zone_reg;
        sts.alarm_now  = alarm_reg;
        sts.out_free   = !result_valid_reg || !result_stall;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

FILE: rtl/core/rgb_led_fade_controller.sv
`default_nettype none
// A result beat is registered once its event beat has passed the decode, apply and
// result steps of the controller FSM; a new event is taken only while the FSM is idle,
// and a stalled result register holds the FSM in its last step.
// Asynchronous reset sets color all ones, mode off and level registers zero.
// Top level of the RGB LED fade controller; depends on rlf_pkg, rlf_ctrl and rlf_datapath.
module rgb_led_fade_controller (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  rlf_pkg::item_t                          item,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output rlf_pkg::result_t                        result,
    input  wire logic                               cfg_we,
    input  wire logic [rlf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [rlf_pkg::LEVEL_BITS-1:0]     cfg_data
);
    import rlf_pkg::*;

    ctl_t ctl;
    sts_t sts;

    rlf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .ctl        (ctl)
    );

    rlf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .ctl          (ctl),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for rgb_led_fade_controller: directed and random events
// are checked beat by beat against an in-bench model of the fade engine.
// Depends on rlf_pkg and the rgb_led_fade_controller RTL only.
module tb_top;
    import rlf_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_SPARE_B = 3'd7;
    localparam int HOLD_CYCLES = 150;

    typedef enum {
        PLAN_SHOWCASE,
        PLAN_NEAR,
        PLAN_DARK,
        PLAN_BRIGHT,
        PLAN_CHECKER
    } level_plan_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [LEVEL_BITS-1:0] cfg_data = '0;

    logic [LEVEL_BITS-1:0] level_reg [NUM_LEVELS];
    logic [COLOUR_BITS-1:0] lamp_now [3];
    logic [COLOUR_BITS-1:0] lamp_base [3];
    logic signed [COLOUR_BITS:0] lamp_delta [3];
    logic [7:0] fade_steps;
    logic [7:0] steps_taken;
    logic [INTERVAL_BITS-1:0] tick_count;
    logic [INTERVAL_BITS-1:0] step_gap;
    logic fade_on;
    logic [MODE_BITS-1:0] mode_cur;
    logic [ZONE_BITS-1:0] zone_cur;
    logic alarm_cur;

    result_t status_due [$];
    int mismatches = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    logic hold_request = 1'b0;
    int hold_left = 0;

    rgb_led_fade_controller uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    function automatic void clear_lamp_model();
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            level_reg[i] = '0;
        end
        for (int c = 0; c < 3; c++)
        begin
            lamp_now[c] = '1;
            lamp_base[c] = '0;
            lamp_delta[c] = '0;
        end
        fade_steps = '0;
        steps_taken = '0;
        tick_count = '0;
        step_gap = '0;
        fade_on = 1'b0;
        mode_cur = MODE_OFF;
        zone_cur = '0;
        alarm_cur = 1'b0;
    endfunction

    function automatic void begin_fade(input logic [COLOUR_BITS-1:0] tr,
                                       input logic [COLOUR_BITS-1:0] tg,
                                       input logic [COLOUR_BITS-1:0] tb,
                                       input logic [INTERVAL_BITS-1:0] gap);
        logic [COLOUR_BITS-1:0] goal [3];
        int most;
        int d;
        goal[0] = tr;
        goal[1] = tg;
        goal[2] = tb;
        most = 0;
        for (int c = 0; c < 3; c++)
        begin
            d = int'(goal[c]) - int'(lamp_now[c]);
            if (d < 0)
                d = -d;
            if (d > most)
                most = d;
        end
        if (most == 0)
        begin
            fade_on = 1'b0;
            return;
        end
        for (int c = 0; c < 3; c++)
        begin
            lamp_base[c] = lamp_now[c];
            lamp_delta[c] = 9'(int'(goal[c]) - int'(lamp_now[c]));
        end
        fade_steps = 8'(most);
        steps_taken = '0;
        tick_count = '0;
        step_gap = gap;
        fade_on = 1'b1;
    endfunction

    function automatic void fade_to_level(input logic [LEVEL_IDX_BITS-1:0] idx,
                                          input logic [INTERVAL_BITS-1:0] gap);
        logic [LEVEL_BITS-1:0] v;
        v = level_reg[(idx > LVL_OFF) ? LVL_OFF : idx];
        begin_fade(v[3*COLOUR_BITS-1:2*COLOUR_BITS], v[2*COLOUR_BITS-1:COLOUR_BITS],
                   v[COLOUR_BITS-1:0], gap);
    endfunction

    function automatic void take_tick();
        int num;
        int q;
        int tot;
        if (!fade_on)
            return;
        if (tick_count < step_gap)
        begin
            tick_count = tick_count + 1'b1;
            return;
        end
        tick_count = '0;
        steps_taken = steps_taken + 1'b1;
        tot = int'(fade_steps);
        for (int c = 0; c < 3; c++)
        begin
            num = int'(lamp_delta[c]) * int'(steps_taken);
            q = num / tot;
            if (num < 0 && q * tot != num)
                q = q - 1;
            lamp_now[c] = COLOUR_BITS'(int'(lamp_base[c]) + q);
        end
        if (steps_taken >= fade_steps)
            fade_on = 1'b0;
    endfunction

    function automatic void change_mode(input logic [MODE_BITS-1:0] m);
        if (m == mode_cur)
            return;
        mode_cur = m;
        case (m)
            MODE_OFF:     fade_to_level(LVL_OFF, SHORT_WAIT);
            MODE_DAY:     fade_to_level(LVL_BRIGHT, LONG_WAIT);
            MODE_EVENING: fade_to_level(zone_cur, LONG_WAIT);
            MODE_NIGHT:   fade_to_level(LVL_NIGHT, LONG_WAIT);
            MODE_HIGH:    fade_to_level(LVL_BRIGHT, SHORT_WAIT);
            MODE_DIM:     fade_to_level(LVL_DIM, SHORT_WAIT);
            MODE_ALL_OFF:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    lamp_now[c] = '1;
                end
                fade_on = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic void night_alarm_fade();
        if (alarm_cur)
            fade_to_level(LVL_DIM, SHORT_WAIT);
        else
            fade_to_level(LVL_NIGHT, LONG_WAIT);
    endfunction

    function automatic result_t next_lamp_status(input item_t ev);
        result_t st;
        case (ev.command)
            CMD_TICK:   take_tick();
            CMD_MODE:   change_mode(ev.mode_value);
            CMD_SENSOR:
            begin
                zone_cur = (ev.zone > ZONE_MAX) ? ZONE_MAX : ev.zone;
                case (mode_cur)
                    MODE_OFF, MODE_DAY: fade_to_level(LVL_BRIGHT, LONG_WAIT);
                    MODE_EVENING:       fade_to_level(zone_cur, LONG_WAIT);
                    MODE_NIGHT:         night_alarm_fade();
                    default: ;
                endcase
            end
            CMD_ALARM:
            begin
                alarm_cur = ev.alarm;
                if (mode_cur == MODE_NIGHT)
                    night_alarm_fade();
            end
            CMD_FADE:   begin_fade(ev.red_in, ev.green_in, ev.blue_in, ev.step_interval);
            CMD_SET:
            begin
                lamp_now[0] = ev.red_in;
                lamp_now[1] = ev.green_in;
                lamp_now[2] = ev.blue_in;
            end
            default: ;
        endcase
        st.red_out = lamp_now[0];
        st.green_out = lamp_now[1];
        st.blue_out = lamp_now[2];
        st.fading = fade_on;
        st.mode_out = mode_cur;
        return st;
    endfunction

    function automatic item_t event_of(input logic [CMD_BITS-1:0] cmd);
        item_t ev;
        ev.command = cmd;
        ev.mode_value = MODE_BITS'($urandom);
        ev.zone = ZONE_BITS'($urandom);
        ev.alarm = 1'($urandom);
        ev.red_in = COLOUR_BITS'($urandom);
        ev.green_in = COLOUR_BITS'($urandom);
        ev.blue_in = COLOUR_BITS'($urandom);
        ev.step_interval = INTERVAL_BITS'($urandom);
        return ev;
    endfunction

    function automatic logic [COLOUR_BITS-1:0] nudge(input logic [COLOUR_BITS-1:0] c);
        return COLOUR_BITS'(int'(c) + int'($urandom_range(8)) - 4);
    endfunction

    function automatic item_t random_event();
        item_t ev;
        int pick;
        int gap_pick;
        pick = $urandom_range(99);
        if (pick < 45)
            ev = event_of(CMD_TICK);
        else if (pick < 55)
            ev = event_of(CMD_MODE);
        else if (pick < 65)
            ev = event_of(CMD_SENSOR);
        else if (pick < 72)
            ev = event_of(CMD_ALARM);
        else if (pick < 93)
        begin
            ev = event_of((pick < 84) ? CMD_FADE : CMD_SET);
            if ($urandom_range(99) < 60)
            begin
                ev.red_in = nudge(lamp_now[0]);
                ev.green_in = nudge(lamp_now[1]);
                ev.blue_in = nudge(lamp_now[2]);
            end
            gap_pick = $urandom_range(9);
            if (gap_pick < 7)
                ev.step_interval = INTERVAL_BITS'($urandom_range(2));
            else if (gap_pick < 9)
                ev.step_interval = INTERVAL_BITS'($urandom_range(30));
        end
        else if (pick < 96)
            ev = event_of(($urandom_range(1) == 0) ? CMD_SPARE_A : CMD_SPARE_B);
        else
            ev = event_of(CMD_BITS'($urandom));
        return ev;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (status_due.size() == 0)
                report_mismatch("result beat with nothing pending", int'(result), 0);
            else
            begin
                want = status_due.pop_front();
                if (result.red_out !== want.red_out)
                    report_mismatch("red_out", result.red_out, want.red_out);
                if (result.green_out !== want.green_out)
                    report_mismatch("green_out", result.green_out, want.green_out);
                if (result.blue_out !== want.blue_out)
                    report_mismatch("blue_out", result.blue_out, want.blue_out);
                if (result.fading !== want.fading)
                    report_mismatch("fading", result.fading, want.fading);
                if (result.mode_out !== want.mode_out)
                    report_mismatch("mode_out", result.mode_out, want.mode_out);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_request && (hold_left == 0))
        begin
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else
            result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    task automatic send_event(input item_t ev);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= ev;
        do
            @(posedge clk);
        while (item_stall);
        status_due.push_back(next_lamp_status(ev));
    endtask

    task automatic drain();
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_level(input int idx, input logic [LEVEL_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= CFG_INDEX_BITS'(idx);
        cfg_data <= value;
        @(posedge clk);
        if (idx < NUM_LEVELS)
            level_reg[idx] = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_levels(input level_plan_t plan);
        logic [LEVEL_BITS-1:0] value;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            case (plan)
                PLAN_SHOWCASE:
                    case (i)
                        0:       value = 24'hFFFFFF;
                        2:       value = 24'h102030;
                        3:       value = 24'hA0B0C0;
                        4:       value = 24'h010203;
                        default: value = 24'h000000;
                    endcase
                PLAN_NEAR:
                    value = {8'(8'h80 + $urandom_range(4) - 2), 8'(8'h80 + $urandom_range(4) - 2),
                             8'(8'h80 + $urandom_range(4) - 2)};
                PLAN_DARK:    value = '0;
                PLAN_BRIGHT:  value = '1;
                default:      value = (i % 2 == 0) ? '0 : '1;
            endcase
            write_level(i, value);
        end
    endtask

    task automatic run_traffic(input int count, input int idle_pct, input int stall_pct,
                               input level_plan_t plan);
        program_levels(plan);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) send_event(random_event());
        item_valid <= 1'b0;
        drain();
    endtask

    task automatic test_directed_events();
        item_t ev;
        program_levels(PLAN_SHOWCASE);
        write_level(NUM_LEVELS, 24'h5A5A5A);
        write_level(NUM_LEVELS + 1, 24'hA5A5A5);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        send_event(event_of(CMD_TICK));
        ev = event_of(CMD_SET);
        ev.red_in = 8'h00;
        ev.green_in = 8'h80;
        ev.blue_in = 8'hFF;
        send_event(ev);
        ev = event_of(CMD_FADE);
        ev.red_in = 8'hFF;
        ev.green_in = 8'h80;
        ev.blue_in = 8'h00;
        ev.step_interval = '0;
        send_event(ev);
        send_event(event_of(CMD_TICK));
        send_event(event_of(CMD_TICK));
        ev = event_of(CMD_FADE);
        ev.red_in = lamp_now[0];
        ev.green_in = lamp_now[1];
        ev.blue_in = lamp_now[2];
        send_event(ev);
        ev = event_of(CMD_FADE);
        ev.red_in = 8'h00;
        ev.green_in = 8'h00;
        ev.blue_in = 8'h00;
        ev.step_interval = '1;
        send_event(ev);
        send_event(event_of(CMD_TICK));
        ev = event_of(CMD_MODE);
        ev.mode_value = MODE_OFF;
        send_event(ev);
        ev.mode_value = MODE_DAY;
        send_event(ev);
        ev.mode_value = MODE_EVENING;
        send_event(ev);
        ev.mode_value = MODE_NIGHT;
        send_event(ev);
        ev = event_of(CMD_ALARM);
        ev.alarm = 1'b1;
        send_event(ev);
        ev = event_of(CMD_SENSOR);
        ev.zone = 3'd7;
        send_event(ev);
        ev = event_of(CMD_ALARM);
        ev.alarm = 1'b0;
        send_event(ev);
        ev = event_of(CMD_MODE);
        ev.mode_value = MODE_HIGH;
        send_event(ev);
        ev = event_of(CMD_SENSOR);
        ev.zone = 3'd4;
        send_event(ev);
        ev = event_of(CMD_MODE);
        ev.mode_value = MODE_MANUAL;
        send_event(ev);
        ev.mode_value = MODE_EVENING;
        send_event(ev);
        ev = event_of(CMD_SET);
        ev.red_in = 8'h12;
        ev.green_in = 8'h34;
        ev.blue_in = 8'h56;
        send_event(ev);
        send_event(event_of(CMD_TICK));
        ev = event_of(CMD_MODE);
        ev.mode_value = MODE_ALL_OFF;
        send_event(ev);
        send_event(event_of(CMD_SPARE_A));
        send_event(event_of(CMD_SPARE_B));
        ev = event_of(CMD_MODE);
        ev.mode_value = MODE_OFF;
        send_event(ev);
        item_valid <= 1'b0;
        drain();
    endtask

    task automatic test_streaming();
        run_traffic(170, 0, 0, PLAN_NEAR);
    endtask

    task automatic test_sender_gaps();
        run_traffic(170, 75, 0, PLAN_DARK);
    endtask

    task automatic test_receiver_stalls();
        run_traffic(170, 0, 75, PLAN_BRIGHT);
    endtask

    task automatic test_mixed_idling();
        run_traffic(170, 33, 33, PLAN_CHECKER);
    endtask

    task automatic test_backpressure();
        program_levels(PLAN_NEAR);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        @(negedge clk);
        hold_request = 1'b1;
        @(negedge clk);
        hold_request = 1'b0;
        @(posedge clk);
        repeat (30) send_event(random_event());
        item_valid <= 1'b0;
        drain();
    endtask

    initial
    begin
        clear_lamp_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_events();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_backpressure();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: rgb_led_fade_controller.f
rtl/core/rlf_pkg.sv
rtl/core/rlf_ctrl.sv
rtl/core/rlf_datapath.sv
rtl/core/rgb_led_fade_controller.sv
tb/tb_top.sv
